FILE: rtl/drti_pkg.sv
// Shared types and constants for the double round-to-integral block.
`timescale 1ns / 1ps
package drti_pkg;
    typedef enum logic [1:0] {
        MODE_FLOOR = 2'd0,
        MODE_CEIL  = 2'd1,
        MODE_TRUNC = 2'd2,
        MODE_ROUND = 2'd3
    } mode_t;

    localparam logic [10:0] EXP_BIAS  = 11'd1023;
    localparam logic [10:0] EXP_BIG   = 11'd1075;
    localparam logic [63:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;

    typedef struct packed {
        logic        pass;
        logic        below_one;
        logic        neg;
        logic        nonzero;
        logic        half_up;
        mode_t       mode;
        logic [5:0]  shift;
    } dec_t;
endpackage

FILE: rtl/drti_core.sv
// Four-stage pipeline: decode, mask build, bump decision, increment.
`timescale 1ns / 1ps
module drti_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  drti_pkg::mode_t       in_mode,
    input  logic [63:0]           in_bits,
    output logic                  out_valid,
    output logic [63:0]           out_bits
);
    import drti_pkg::*;

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic [63:0] x1_reg, x2_reg, x3_reg, r4_reg;
    dec_t        d1_reg, d2_reg, d3_reg;
    dec_t        d1_next;
    logic [63:0] low2_reg, low2_next;
    logic [63:0] inc3_reg;
    logic        bump3_reg, bump3_next;
    logic [63:0] frac2;
    logic [10:0] e;
    logic [11:0] s_wide;

    always_comb
    begin
        e = in_bits[62:52];
        s_wide = {1'b0, EXP_BIG} - {1'b0, e};
        d1_next.pass      = (e >= EXP_BIG);
        d1_next.below_one = (e < EXP_BIAS);
        d1_next.neg       = in_bits[63];
        d1_next.nonzero   = |in_bits[62:0];
        d1_next.half_up   = (e >= EXP_BIAS - 11'd1);
        d1_next.mode      = in_mode;
        d1_next.shift     = s_wide[5:0];
    end

    // already integral words keep every bit
    always_comb
    begin
        if (d1_reg.pass)
            low2_next = 64'd0;
        else
            low2_next = (64'd1 << d1_reg.shift) - 64'd1;
    end

    always_comb
    begin
        frac2 = x2_reg & low2_reg;
        bump3_next = 1'b0;
        case (d2_reg.mode)
            MODE_FLOOR: bump3_next = d2_reg.neg &
                (d2_reg.below_one ? d2_reg.nonzero : (frac2 != 64'd0));
            MODE_CEIL:  bump3_next = !d2_reg.neg &
                (d2_reg.below_one ? d2_reg.nonzero : (frac2 != 64'd0));
            MODE_TRUNC: bump3_next = 1'b0;
            default:    bump3_next = d2_reg.below_one ? d2_reg.half_up :
                (frac2 > (low2_reg >> 1));
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg    <= in_bits;
        d1_reg    <= d1_next;
        x2_reg    <= x1_reg;
        d2_reg    <= d1_reg;
        low2_reg  <= low2_next;
        x3_reg    <= x2_reg & ~low2_reg;
        d3_reg    <= d2_reg;
        inc3_reg  <= low2_reg + 64'd1;
        bump3_reg <= bump3_next;
        if (d3_reg.pass)
            r4_reg <= x3_reg;
        else if (d3_reg.below_one)
            r4_reg <= bump3_reg ? ({d3_reg.neg, 63'd0} | ONE_BITS) : 64'd0;
        else
            r4_reg <= bump3_reg ? (x3_reg + inc3_reg) : x3_reg;
    end

    assign out_valid = v4_reg;
    assign out_bits  = r4_reg;
endmodule

FILE: rtl/double_round_to_integral_top.sv
// Top level of the double round-to-integral block.
// Rounds an IEEE-754 binary64 word to an integral value.
// A word is taken on a clock edge with start high; busy is always low,
// so a new word may enter every cycle.
// req_type: 0 floor, 1 ceiling, 2 truncate, 3 round half away from zero.
// result_bits is on the ports once the word has passed the core pipeline
// registers, marked by done for exactly one cycle, and is taken while done is high;
// results come out in input order.
// Throughput: one word per cycle, set by the four-stage core pipeline.
// NaN, infinity and magnitudes of 2^52 or more pass unchanged; zero
// results are +0.
// Reset clears the pipeline valid bits; words in flight are dropped.
// The receiver cannot stall: it must take done when it appears.
`timescale 1ns / 1ps
module double_round_to_integral_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [63:0] value_bits,
    output logic        done,
    output logic [63:0] result_bits
);
    import drti_pkg::*;

    assign busy = 1'b0;

    drti_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .in_mode   (mode_t'(req_type)),
        .in_bits   (value_bits),
        .out_valid (done),
        .out_bits  (result_bits)
    );
endmodule

FILE: rtl/drti_checker.sv
// Port-level checks for the double round-to-integral block.
`timescale 1ns / 1ps
module drti_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [63:0] value_bits,
    input logic        done,
    input logic [63:0] result_bits
);
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("result missing four cycles after accept");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("result without input");

    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result_bits != 64'h8000_0000_0000_0000))
        else $error("negative zero result");

    a_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && value_bits[62:52] == 11'h7FF) |-> ##4
        (result_bits == $past(value_bits, 4)))
        else $error("NaN or infinity altered");
endmodule

bind double_round_to_integral_top drti_checker u_drti_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .value_bits  (value_bits),
    .done        (done),
    .result_bits (result_bits)
);

FILE: bench/double_round_to_integral_top_tb.sv
// Self-checking testbench for the double round-to-integral block.
`timescale 1ns / 1ps
module double_round_to_integral_top_tb;
    import drti_pkg::*;

    class rounding_scoreboard;
        logic [63:0] pending_q[$];
        int errors;
        int checked;

        function logic [63:0] round_word(mode_t mode, logic [63:0] x);
            logic        neg;
            logic [10:0] e;
            logic        bump;
            logic        nonzero;
            int          s;
            logic [63:0] low;
            logic [63:0] frac;
            logic [63:0] r;
            neg = x[63];
            e = x[62:52];
            nonzero = x[62:0] != 0;
            if (e >= 11'd1075)
                return x;
            if (e < 11'd1023)
            begin
                case (mode)
                    MODE_FLOOR: bump = neg && nonzero;
                    MODE_CEIL:  bump = !neg && nonzero;
                    MODE_TRUNC: bump = 1'b0;
                    default:    bump = e >= 11'd1022;
                endcase
                if (!bump)
                    return 64'd0;
                return {neg, 63'd0} | 64'h3FF0_0000_0000_0000;
            end
            s = 1075 - int'(e);
            low = (64'd1 << s) - 64'd1;
            frac = x & low;
            r = x & ~low;
            case (mode)
                MODE_FLOOR: bump = neg && frac != 0;
                MODE_CEIL:  bump = !neg && frac != 0;
                MODE_TRUNC: bump = 1'b0;
                default:    bump = frac >= (64'd1 << (s - 1));
            endcase
            if (bump)
                r = r + (64'd1 << s);
            return r;
        endfunction

        function void note_word(mode_t mode, logic [63:0] x);
            pending_q.push_back(round_word(mode, x));
        endfunction

        function void check_result(logic [63:0] got);
            logic [63:0] want;
            checked++;
            if (pending_q.size() == 0)
            begin
                $error("result_bits: unexpected word, actual %h", got);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (got !== want)
            begin
                $error("result_bits: expected %h, actual %h", want, got);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  req_type;
    logic [63:0] value_bits;
    logic        done;
    logic [63:0] result_bits;

    rounding_scoreboard sb;
    int sent;
    int idle_pct;

    double_round_to_integral_top u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req_type(req_type),
        .value_bits(value_bits),
        .done(done),
        .result_bits(result_bits)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result_bits);
    end

    // Drives one word; holds start until accepted, then optional idle gap.
    task automatic send_word(mode_t mode, logic [63:0] x);
        start <= 1'b1;
        req_type <= mode;
        value_bits <= x;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_word(mode, x);
        sent++;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3))
                @(posedge clk);
        end
    endtask

    function automatic logic [63:0] rand_double();
        logic [63:0] x;
        logic [10:0] e;
        x = {$urandom, $urandom};
        case ($urandom_range(5))
            0: e = 11'($urandom_range(1023, 1075));
            1: e = 11'($urandom_range(1018, 1030));
            2: e = 11'($urandom_range(1068, 1080));
            3: e = x[62:52];
            4: e = $urandom_range(1) ? 11'h7FF : 11'd0;
            default: e = 11'($urandom_range(1000, 1100));
        endcase
        x[62:52] = e;
        case ($urandom_range(7))
            0: x[51:0] = '1;
            1: x[51:0] = 52'd0;
            2: x[51:0] = 52'h8_0000_0000_0000;
            default: ;
        endcase
        return x;
    endfunction

    initial
    begin
        logic [63:0] directed[$];
        sb = new();
        sent = 0;
        idle_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        req_type = MODE_FLOOR;
        value_bits = 64'd0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
                     64'h3FE0_0000_0000_0000, 64'hBFE0_0000_0000_0000,
                     64'h3FF8_0000_0000_0000, 64'hC004_0000_0000_0000,
                     64'h7FF0_0000_0000_0000, 64'hFFF8_0000_DEAD_BEEF,
                     64'h4330_0000_0000_0001, 64'h432F_FFFF_FFFF_FFFF,
                     64'hBFEF_FFFF_FFFF_FFFF, 64'h3FDF_FFFF_FFFF_FFFF,
                     64'h0000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF,
                     64'h400F_FFFF_FFFF_FFFF};
        foreach (directed[i])
            for (int m = 0; m < 4; m++)
                if (i < 6 || m == i % 4 || m == 3)
                    send_word(mode_t'(m), directed[i]);

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 26 : (phase == 1) ? 66 : 0;
            repeat (280)
                send_word(mode_t'($urandom_range(3)), rand_double());
        end
        start <= 1'b0;

        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
        $display("Rounded %0d words over all four modes, %0d results checked.",
                 sent, sb.checked);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

FILE: files.f
rtl/drti_pkg.sv
rtl/drti_core.sv
rtl/double_round_to_integral_top.sv
rtl/drti_checker.sv
bench/double_round_to_integral_top_tb.sv
